FILE: design/assert_macros.svh
// Assertion macros for the stepper core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// cond must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// cons must hold in the cycle after ante
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rst, cond, msg)
`define AST_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/ivds_pkg.sv
package ivds_pkg;

  // register map
  typedef enum logic [2:0] {
    REG_TARGET  = 3'd0,
    REG_DEFAULT = 3'd1,
    REG_MIN     = 3'd2,
    REG_MAX     = 3'd3,
    REG_HOLD    = 3'd4,
    REG_INC     = 3'd5,
    REG_DEC     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_CRANK    = 3'd0,
    ACT_VERY_LOW = 3'd1,
    ACT_HOLD     = 3'd2,
    ACT_IN_BAND  = 3'd3,
    ACT_HIGH     = 3'd4,
    ACT_BIT_HIGH = 3'd5,
    ACT_LOW      = 3'd6,
    ACT_BIT_LOW  = 3'd7
  } action_t;

  localparam int unsigned BAND_LO_PCT = 93;
  localparam int unsigned BAND_HI_PCT = 107;
  localparam int unsigned RPM_MARGIN  = 100;
  localparam int unsigned LOW_NUM     = 7;   // very low: 10*rpm < 7*band_low
  localparam int unsigned LOW_DEN     = 10;
  // floor(x/100) = (x * ceil(2^30/100)) >> 30, exact for x < 2^23
  localparam int unsigned BAND_SHIFT  = 30;
  localparam logic [23:0] BAND_RECIP  = 24'd10737419;

  localparam logic [15:0] TARGET_RST  = 16'd1000;
  localparam logic [7:0]  DEFAULT_RST = 8'd20;
  localparam logic [7:0]  MIN_RST     = 8'd0;
  localparam logic [7:0]  MAX_RST     = 8'd255;
  localparam logic [7:0]  HOLD_RST    = 8'd1;
  localparam logic [7:0]  INC_RST     = 8'd1;
  localparam logic [7:0]  DEC_RST     = 8'd1;

  typedef struct packed {
    logic [15:0] rpm;
    logic        cranking;
    logic [31:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic [7:0] duty;
    action_t    action;
    logic       changed;
  } out_t;

  typedef struct packed {
    logic [15:0] target_rpm;
    logic [7:0]  default_duty;
    logic [7:0]  min_duty;
    logic [7:0]  max_duty;
    logic [7:0]  hold_seconds;
    logic [7:0]  increase_step;
    logic [7:0]  decrease_step;
  } cfg_t;

  // band edges derived from target_rpm
  typedef struct packed {
    logic [15:0] low;
    logic [16:0] high;
    logic [18:0] low7;
  } band_t;

endpackage

FILE: design/ivds_band.sv
// Band edges from target_rpm: constant multiply, reciprocal multiply, times 7.
// busy covers the pipeline latency after target_rpm changes.
module ivds_band (
  input  logic              clk,
  input  logic              rst,
  input  logic              reload,
  input  logic [15:0]       target_rpm,
  output ivds_pkg::band_t   band,
  output logic              busy
);

  localparam logic [1:0] BUSY_CYCLES = 2'd3;

  logic [22:0] p_lo;
  logic [22:0] p_hi;
  logic [46:0] q_lo;
  logic [46:0] q_hi;
  logic [15:0] low;
  logic [16:0] high;
  logic [18:0] low7;
  logic [1:0]  busy_cnt;

  always_ff @(posedge clk) begin
    p_lo <= 23'({7'd0, target_rpm} * 23'(ivds_pkg::BAND_LO_PCT));
    p_hi <= 23'({7'd0, target_rpm} * 23'(ivds_pkg::BAND_HI_PCT));
    low  <= q_lo[ivds_pkg::BAND_SHIFT +: 16];
    high <= q_hi[ivds_pkg::BAND_SHIFT +: 17];
    low7 <= 19'({3'd0, low} * 19'(ivds_pkg::LOW_NUM));
  end

  assign q_lo = {24'd0, p_lo} * {23'd0, ivds_pkg::BAND_RECIP};
  assign q_hi = {24'd0, p_hi} * {23'd0, ivds_pkg::BAND_RECIP};

  // reset also waits the pipeline out, so the edges start from the reset target
  always_ff @(posedge clk) begin
    if (rst || reload) begin
      busy_cnt <= BUSY_CYCLES;
    end else if (busy_cnt != 2'd0) begin
      busy_cnt <= busy_cnt - 2'd1;
    end
  end

  assign busy      = (busy_cnt != 2'd0);
  assign band.low  = low;
  assign band.high = high;
  assign band.low7 = low7;

endmodule

FILE: design/ivds_step.sv
// One update: rule selection, step, clamp, change detect.
module ivds_step #(
  parameter int CUR_W      = 8,
  parameter int DUTY_WIDTH = 8,
  parameter int TIME_WIDTH = 32
) (
  input  ivds_pkg::in_t           item,
  input  ivds_pkg::cfg_t          cfg,
  input  ivds_pkg::band_t         band,
  input  logic [CUR_W-1:0]        cur_duty,
  input  logic [TIME_WIDTH-1:0]   last_change,
  output logic [CUR_W-1:0]        new_duty,
  output ivds_pkg::out_t          result
);

  localparam int SW = CUR_W + 2;
  localparam logic signed [SW-1:0] ONE_S   = SW'(1);
  localparam logic signed [SW-1:0] ZERO_S  = SW'(0);
  localparam logic signed [SW-1:0] LIMIT_S = SW'((1 << DUTY_WIDTH) - 1);

  logic [19:0]            rpm10;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   apply;
  ivds_pkg::action_t      action;
  logic signed [SW-1:0]   cur_s;
  logic signed [SW-1:0]   want;
  logic signed [SW-1:0]   min_s;
  logic signed [SW-1:0]   max_s;
  logic signed [SW-1:0]   v1;
  logic signed [SW-1:0]   v2;
  logic signed [SW-1:0]   v3;
  logic signed [SW-1:0]   v4;

  assign rpm10   = 20'({4'd0, item.rpm} * 20'(ivds_pkg::LOW_DEN));
  assign elapsed = item.now_seconds[TIME_WIDTH-1:0] - last_change;
  assign cur_s   = $signed({2'b00, cur_duty});
  assign min_s   = $signed({{(SW-8){1'b0}}, cfg.min_duty});
  assign max_s   = $signed({{(SW-8){1'b0}}, cfg.max_duty});

  always_comb begin
    apply  = 1'b1;
    want   = $signed({{(SW-8){1'b0}}, cfg.default_duty});
    priority if (item.rpm == 16'd0 || item.cranking) begin
      action = ivds_pkg::ACT_CRANK;
    end else if (rpm10 < {1'b0, band.low7}) begin
      action = ivds_pkg::ACT_VERY_LOW;
    end else if (elapsed < TIME_WIDTH'(cfg.hold_seconds)) begin
      action = ivds_pkg::ACT_HOLD;
      apply  = 1'b0;
    end else if ({1'b0, item.rpm} > {1'b0, band.low} && {1'b0, item.rpm} < band.high) begin
      action = ivds_pkg::ACT_IN_BAND;
      apply  = 1'b0;
    end else if ({2'b00, item.rpm} >= {1'b0, band.high} + 18'(ivds_pkg::RPM_MARGIN)) begin
      action = ivds_pkg::ACT_HIGH;
      want   = cur_s - $signed({{(SW-8){1'b0}}, cfg.decrease_step});
    end else if ({1'b0, item.rpm} >= band.high) begin
      action = ivds_pkg::ACT_BIT_HIGH;
      want   = cur_s - ONE_S;
    end else if ({1'b0, item.rpm} + 17'(ivds_pkg::RPM_MARGIN) < {1'b0, band.low}) begin
      action = ivds_pkg::ACT_LOW;
      want   = cur_s + $signed({{(SW-8){1'b0}}, cfg.increase_step});
    end else begin
      action = ivds_pkg::ACT_BIT_LOW;
      want   = cur_s + ONE_S;
    end
  end

  // raise to min, then lower to max, then saturate to the duty range
  assign v1 = (want < min_s) ? min_s : want;
  assign v2 = (v1 > max_s) ? max_s : v1;
  assign v3 = (v2 < ZERO_S) ? ZERO_S : v2;
  assign v4 = (v3 > LIMIT_S) ? LIMIT_S : v3;

  assign new_duty       = apply ? v4[CUR_W-1:0] : cur_duty;
  assign result.duty    = 8'({{8{1'b0}}, new_duty});
  assign result.action  = action;
  assign result.changed = (new_duty != cur_duty);

endmodule

FILE: design/idle_valve_duty_stepper_core.sv
// Idle valve duty stepper. Takes one item (rpm, cranking flag, time in seconds)
// per clock while in_ready is high and returns one result item (duty, action,
// changed) for it via the input register, then the result register. The rate is
// one item per cycle while out_ready is high: the duty and last-change time are
// updated by a single pass of compare, add and clamp logic between the input
// register and the result register, so each item sees the state left by the one
// before it. A result waiting on the output register does not block the input
// register; the input side stalls when both registers are full and out_ready is
// low. After reset and after every write of target_rpm, in_ready stays low
// while the band edge pipeline (percent multiply, reciprocal divide by 100,
// times 7) settles. Configuration registers are written through cfg_we/cfg_index/
// cfg_data with no wait; an index outside the register map is ignored.
`include "assert_macros.svh"

module idle_valve_duty_stepper_core #(
  parameter int DUTY_WIDTH = 8,   // 4..16, duty saturates at 2^DUTY_WIDTH-1
  parameter int TIME_WIDTH = 32   // 8..32, elapsed time taken modulo 2^TIME_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ivds_pkg::in_t    in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output ivds_pkg::out_t   out_item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data
);

  // duty storage also has to hold the 8-bit default duty at reset
  localparam int CUR_W = (DUTY_WIDTH > 8) ? DUTY_WIDTH : 8;

  ivds_pkg::cfg_t         cfg;
  ivds_pkg::band_t        band;
  logic                   band_busy;
  logic                   target_wr;

  ivds_pkg::in_t          in_q;
  logic                   in_q_valid;
  ivds_pkg::out_t         out_q;

  logic [CUR_W-1:0]       cur_duty;
  logic [TIME_WIDTH-1:0]  last_change;
  logic [CUR_W-1:0]       duty_next;
  ivds_pkg::out_t         step_res;

  logic                   advance;   // result register can take a new item
  logic                   out_load;
  logic                   in_take;

  // ---- configuration registers ----
  assign target_wr = cfg_we && (cfg_index == ivds_pkg::REG_TARGET);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_rpm    <= ivds_pkg::TARGET_RST;
      cfg.default_duty  <= ivds_pkg::DEFAULT_RST;
      cfg.min_duty      <= ivds_pkg::MIN_RST;
      cfg.max_duty      <= ivds_pkg::MAX_RST;
      cfg.hold_seconds  <= ivds_pkg::HOLD_RST;
      cfg.increase_step <= ivds_pkg::INC_RST;
      cfg.decrease_step <= ivds_pkg::DEC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ivds_pkg::REG_TARGET:  cfg.target_rpm    <= cfg_data;
        ivds_pkg::REG_DEFAULT: cfg.default_duty  <= cfg_data[7:0];
        ivds_pkg::REG_MIN:     cfg.min_duty      <= cfg_data[7:0];
        ivds_pkg::REG_MAX:     cfg.max_duty      <= cfg_data[7:0];
        ivds_pkg::REG_HOLD:    cfg.hold_seconds  <= cfg_data[7:0];
        ivds_pkg::REG_INC:     cfg.increase_step <= cfg_data[7:0];
        ivds_pkg::REG_DEC:     cfg.decrease_step <= cfg_data[7:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---- band edges, recomputed whenever target_rpm is written ----
  ivds_band u_band (
    .clk        (clk),
    .rst        (rst),
    .reload     (target_wr),
    .target_rpm (cfg.target_rpm),
    .band       (band),
    .busy       (band_busy)
  );

  // ---- handshake ----
  assign advance  = !out_valid || out_ready;
  assign out_load = in_q_valid && advance;
  assign in_ready = !band_busy && (!in_q_valid || advance);
  assign in_take  = in_valid && in_ready;

  // ---- update logic ----
  ivds_step #(
    .CUR_W      (CUR_W),
    .DUTY_WIDTH (DUTY_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .item        (in_q),
    .cfg         (cfg),
    .band        (band),
    .cur_duty    (cur_duty),
    .last_change (last_change),
    .new_duty    (duty_next),
    .result      (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (out_load) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_item;
    end
  end

  // result register and controller state; state moves only when an item retires
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      cur_duty    <= CUR_W'(ivds_pkg::DEFAULT_RST);
      last_change <= '0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      cur_duty  <= duty_next;
      if (step_res.changed) begin
        last_change <= in_q.now_seconds[TIME_WIDTH-1:0];
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= step_res;
    end
  end

  assign out_item = out_q;

  // ---- checks ----
  // no item may enter while band edges are stale
  `AST_NEXT(a_target_stall, clk, rst, target_wr, !in_ready, "item accepted with stale band edges")
  // a change stamps the item's time
  `AST_NEXT(a_stamp, clk, rst, out_load && step_res.changed, last_change == $past(in_q.now_seconds[TIME_WIDTH-1:0]), "last change time not stamped")
  // hold and in-band results never change the duty
  `AST_HOLDS(a_hold_quiet, clk, rst, !(out_valid && (out_item.action == ivds_pkg::ACT_HOLD || out_item.action == ivds_pkg::ACT_IN_BAND)) || !out_item.changed, "duty changed on hold or in band")

endmodule
